/* rtl/hfxd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfxd_pkg
// Shared types and constants of the framed serial byte decoder.
// ----------------------------------------------------------------------------
package hfxd_pkg;

    localparam int PAYLOAD_MAX_DEF = 32;

    // Frame count field, wide enough for a payload count of up to 127.
    localparam int CNT_W = 7;

    // One finished frame waiting to be drained from the payload store.
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
    } t_desc;

    // Back end hands a payload bank back to the front end.
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage
`default_nettype wire

/* rtl/hfxd_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfxd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hfxd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/hfxd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfxd_front
// Header parser: matches the header, length and separator, writes payload
// bytes into one of two store banks and posts a descriptor on a good checksum.
// ----------------------------------------------------------------------------
module hfxd_front
    import hfxd_pkg::*;
#(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_rx_valid,
    output logic                                    o_rx_stall,
    input  wire logic [7:0]                         i_rx_byte,
    output logic                                    o_we,
    output logic [$clog2(2*PAYLOAD_MAX)-1:0]        o_waddr,
    output logic [7:0]                              o_wdata,
    output logic                                    o_push,
    output t_desc                                   o_desc,
    input  wire t_release                           i_release
);

    localparam int FW = $clog2(PAYLOAD_MAX + 1);
    localparam int AW = $clog2(2 * PAYLOAD_MAX);

    localparam logic [2:0] ST_WAIT_U   = 3'd0;
    localparam logic [2:0] ST_WAIT_N   = 3'd1;
    localparam logic [2:0] ST_WAIT_E   = 3'd2;
    localparam logic [2:0] ST_WAIT_R   = 3'd3;
    localparam logic [2:0] ST_WAIT_LEN = 3'd4;
    localparam logic [2:0] ST_WAIT_SEP = 3'd5;
    localparam logic [2:0] ST_PAYLOAD  = 3'd6;

    localparam logic [7:0] CH_U   = 8'h55;
    localparam logic [7:0] CH_N   = 8'h4E;
    localparam logic [7:0] CH_E   = 8'h45;
    localparam logic [7:0] CH_R   = 8'h52;
    localparam logic [7:0] CH_SEP = 8'h3A;
    localparam logic [7:0] HDR_XOR = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_SEP;

    logic [2:0]    r_state, n_state;
    logic [7:0]    r_rem,   n_rem;
    logic [7:0]    r_xor,   n_xor;
    logic [FW-1:0] r_fill,  n_fill;
    logic          r_wbank, n_wbank;
    logic [1:0]    r_busy,  n_busy;

    logic accept;
    logic push;

    assign o_rx_stall = (r_state == ST_PAYLOAD) && r_busy[r_wbank];
    assign accept     = i_rx_valid && !o_rx_stall;

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_xor   = r_xor;
        n_fill  = r_fill;
        n_wbank = r_wbank;
        push    = 1'b0;
        o_we    = 1'b0;
        if (accept) begin
            unique case (r_state)
                ST_WAIT_N: n_state = (i_rx_byte == CH_N) ? ST_WAIT_E : ST_WAIT_U;
                ST_WAIT_E: n_state = (i_rx_byte == CH_E) ? ST_WAIT_R : ST_WAIT_U;
                ST_WAIT_R: n_state = (i_rx_byte == CH_R) ? ST_WAIT_LEN : ST_WAIT_U;
                ST_WAIT_LEN: begin
                    n_rem   = i_rx_byte;
                    n_fill  = '0;
                    n_xor   = HDR_XOR ^ i_rx_byte;
                    n_state = ST_WAIT_SEP;
                end
                ST_WAIT_SEP: n_state = (i_rx_byte == CH_SEP) ? ST_PAYLOAD : ST_WAIT_U;
                ST_PAYLOAD: begin
                    if (r_rem > 8'd1) begin
                        if (r_fill >= FW'(PAYLOAD_MAX)) begin
                            n_state = ST_WAIT_U;
                        end else begin
                            o_we   = 1'b1;
                            n_fill = r_fill + FW'(1);
                            n_xor  = r_xor ^ i_rx_byte;
                            n_rem  = r_rem - 8'd1;
                        end
                    end else begin
                        if ((r_xor == i_rx_byte) && (r_fill != '0)) begin
                            push    = 1'b1;
                            n_wbank = !r_wbank;
                        end
                        n_state = ST_WAIT_U;
                    end
                end
                default: n_state = (i_rx_byte == CH_U) ? ST_WAIT_N : ST_WAIT_U;
            endcase
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (push) begin
            n_busy[r_wbank] = 1'b1;
        end
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WAIT_U;
            r_rem   <= '0;
            r_xor   <= '0;
            r_fill  <= '0;
            r_wbank <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_state <= n_state;
            r_rem   <= n_rem;
            r_xor   <= n_xor;
            r_fill  <= n_fill;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
        end
    end

    assign o_waddr = r_wbank ? (AW'(PAYLOAD_MAX) + AW'(r_fill)) : AW'(r_fill);
    assign o_wdata = i_rx_byte;
    assign o_push  = push;
    assign o_desc  = '{bank: r_wbank, count: CNT_W'(r_fill)};

endmodule
`default_nettype wire

/* rtl/hfxd_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfxd_queue
// Two-entry descriptor queue between the parser and the drain side.
// ----------------------------------------------------------------------------
module hfxd_queue
    import hfxd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_desc,
    input  wire logic  i_pop,
    output logic       o_nonempty,
    output logic       o_full,
    output t_desc      o_desc
);

    t_desc      r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    assign o_nonempty = (r_cnt != 2'd0);
    assign o_full     = (r_cnt == 2'd2);
    assign o_desc     = r_ent[r_rp];

endmodule
`default_nettype wire

/* rtl/hfxd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfxd_back
// Drain side: takes a descriptor, reads the stored payload bank byte by
// byte and presents each byte through an output register.
// ----------------------------------------------------------------------------
module hfxd_back
    import hfxd_pkg::*;
#(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_desc_valid,
    input  wire t_desc                       i_desc,
    output logic                             o_pop,
    output logic                             o_re,
    output logic [$clog2(2*PAYLOAD_MAX)-1:0] o_raddr,
    input  wire logic [7:0]                  i_rdata,
    output t_release                         o_release,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [7:0]                       o_out_byte,
    output logic                             o_is_command,
    output logic                             o_last_byte
);

    localparam int AW = $clog2(2 * PAYLOAD_MAX);

    logic             r_busy;
    logic             r_bank;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_k;
    logic             r_pend, r_pend_cmd, r_pend_last;
    logic             r_ov;
    logic [7:0]       r_ob;
    logic             r_oc, r_ol;
    logic             issue, last_issue;

    assign o_pop      = !r_busy && i_desc_valid;
    assign issue      = r_busy && !r_pend && (!r_ov || !i_out_stall);
    assign last_issue = (r_k + CNT_W'(1)) == r_cnt;
    assign o_re       = issue;
    assign o_raddr    = r_bank ? (AW'(PAYLOAD_MAX) + AW'(r_k)) : AW'(r_k);
    assign o_release  = '{valid: issue && last_issue, bank: r_bank};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (issue && last_issue) begin
                r_busy <= 1'b0;
            end
            r_pend <= issue;
            if (r_pend) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bank <= i_desc.bank;
            r_cnt  <= i_desc.count;
            r_k    <= '0;
        end else if (issue) begin
            r_k <= r_k + CNT_W'(1);
        end
        if (issue) begin
            r_pend_cmd  <= (r_k == '0);
            r_pend_last <= last_issue;
        end
        if (r_pend) begin
            r_ob <= i_rdata;
            r_oc <= r_pend_cmd;
            r_ol <= r_pend_last;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_out_byte   = r_ob;
    assign o_is_command = r_oc;
    assign o_last_byte  = r_ol;

endmodule
`default_nettype wire

/* rtl/header_framed_xor_frame_decoder_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// header_framed_xor_frame_decoder_unit
// Framed serial byte decoder: header, length byte, XOR checksum; releases
// the payload of a good frame as a run of bytes.
// ----------------------------------------------------------------------------
// Channel  Direction  Signals                                     Transfer
// rx       in         i_rx_valid o_rx_stall i_rx_byte              valid & !stall
// out      out        o_out_valid i_out_stall o_out_byte
//                     o_is_command o_last_byte                     valid & !stall
//
// Parser takes one received byte per cycle while it is not stalling.
// Drain side reads each payload byte from the store (registered read), then
// loads it into the output register before it issues the next read.
// Two store banks: the parser stalls on payload bytes while its bank still holds an undrained frame.
// Synchronous active-low reset; the payload store is not cleared.
// ----------------------------------------------------------------------------
module header_framed_xor_frame_decoder_unit
    import hfxd_pkg::*;
#(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_rx_valid,
    output logic            o_rx_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_is_command,
    output logic            o_last_byte
);

    localparam int DEPTH = 2 * PAYLOAD_MAX;
    localparam int AW    = $clog2(DEPTH);

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;
    logic          push, pop, q_nonempty, q_full;
    t_desc         desc_in, desc_out;
    t_release      release_bank;

    hfxd_front #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .i_rx_byte  (i_rx_byte),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_push     (push),
        .o_desc     (desc_in),
        .i_release  (release_bank)
    );

    hfxd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    hfxd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_desc     (desc_in),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_full     (q_full),
        .o_desc     (desc_out)
    );

    hfxd_back #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (q_nonempty),
        .i_desc       (desc_out),
        .o_pop        (pop),
        .o_re         (re),
        .o_raddr      (raddr),
        .i_rdata      (rdata),
        .o_release    (release_bank),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_is_command (o_is_command),
        .o_last_byte  (o_last_byte)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_full))
        else $error("descriptor pushed into a full queue");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(we && re && (waddr == raddr)))
        else $error("payload write hits the entry being drained");

    a_pushed_frame_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (desc_in.count != '0))
        else $error("empty frame posted for draining");

    a_last_clears_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_byte) |-> !(re && $past(re) && !$past(we)
        && ($past(raddr) == raddr)))
        else $error("drain reread after last byte");

endmodule
`default_nettype wire
